/* src/fat_chain_allocator_assert.svh */
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH

// Both macros expect signals named clk and rst_n in the scope of use.
`define FCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_chain_allocator: same-cycle check failed");

`define FCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fat_chain_allocator: next-cycle check failed");

`endif

/* src/fca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

  localparam int FUNC_W   = 1;
  localparam int LEN_W    = 20;
  localparam int START_W  = 8;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 8;
  localparam int FREE_W   = 9;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;

  // Table entries carry a two-bit tag above the block index.
  localparam int TAG_W = 2;
  localparam logic [TAG_W-1:0] TAG_LINK = 2'd0;
  localparam logic [TAG_W-1:0] TAG_END  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_FREE = 2'd2;

endpackage

`default_nettype wire

/* src/fca_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fca_in_if;
  logic                          valid;
  logic                          ready;
  logic [fca_pkg::FUNC_W-1:0]    func;
  logic [fca_pkg::LEN_W-1:0]     file_length;
  logic [fca_pkg::START_W-1:0]   start_block;

  modport source (output valid, output func, output file_length, output start_block,
                  input ready);
  modport sink   (input valid, input func, input file_length, input start_block,
                  output ready);
endinterface

`default_nettype wire

/* src/fca_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fca_out_if;
  logic                          valid;
  logic                          ready;
  logic [fca_pkg::STATUS_W-1:0]  status;
  logic [fca_pkg::FIRST_W-1:0]   first_block;
  logic [fca_pkg::FREE_W-1:0]    free_total;

  modport source (output valid, output status, output first_block, output free_total,
                  input ready);
  modport sink   (input valid, input status, input first_block, input free_total,
                  output ready);
endinterface

`default_nettype wire

/* src/fat_chain_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Block chain allocator over a table of BLOCKS entries.
// in_ch carries one request per beat: func selects allocate (file_length bytes,
// at least one block) or free (walk the chain from start_block). out_ch returns
// one beat per request with status, first_block and the free count afterwards.
// Requests are handled one at a time; in_ch.ready is high only while idle.
// An allocation checks space (capacity in S_ACAP, compare in S_ACHK), then reads
// and decides on every table entry scanned up to the last block it takes,
// closes the chain in S_AEND and loads the result in S_OUT. A free reads and
// decides on each table entry visited, then loads the result. The table is a
// single-port-read memory, so each visited entry passes through a read state
// and then a decision state; that pair sets the rate.
// The result sits in an output register: a new request is accepted while an
// earlier result is still held, and the block waits only when it has a new
// result and the receiver is still stalled.
// After reset the block marks every table entry free in S_CLEAR and
// accepts no request meanwhile; the free count starts at BLOCKS.
module fat_chain_allocator #(
  parameter int BLOCKS      = 256,
  parameter int BLOCK_BYTES = 2048
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fca_in_if.sink    in_ch,
  fca_out_if.source out_ch
);

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int EW = IW + fca_pkg::TAG_W;
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int AW = $clog2(BLOCKS * BLOCK_BYTES + 1);
  localparam int MW = (AW > fca_pkg::LEN_W) ? AW : fca_pkg::LEN_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACAP, S_ACHK, S_ARD, S_AEV, S_AEND, S_FRD, S_FEV, S_OUT
  } state_t;

  state_t                        state_r;
  logic [IW-1:0]                 idx_r;
  logic [IW-1:0]                 prev_r;
  logic [IW-1:0]                 first_idx_r;
  logic                          have_prev_r;
  logic [AW-1:0]                 acc_r;
  logic [AW-1:0]                 cap_r;
  logic [fca_pkg::LEN_W-1:0]     len_r;
  logic [CW-1:0]                 steps_r;
  logic [CW-1:0]                 free_cnt_r;
  logic [fca_pkg::STATUS_W-1:0]  status_r;

  logic                          out_valid_r;
  logic [fca_pkg::STATUS_W-1:0]  out_status_r;
  logic [fca_pkg::FIRST_W-1:0]   out_first_r;
  logic [fca_pkg::FREE_W-1:0]    out_free_r;

  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [EW-1:0]                 wr_data;
  logic [IW-1:0]                 rd_addr;
  logic [EW-1:0]                 rd_data_r;

  logic [fca_pkg::TAG_W-1:0]     rd_tag;
  logic [AW-1:0]                 acc_nxt;
  logic [CW-1:0]                 steps_nxt;
  logic                          alloc_done;
  logic                          space_ok;

  fca_table #(
    .DEPTH (BLOCKS),
    .ADDR_W(IW),
    .DATA_W(EW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data_r)
  );

  assign rd_tag     = rd_data_r[EW-1:IW];
  assign acc_nxt    = acc_r + AW'(BLOCK_BYTES);
  assign steps_nxt  = steps_r + CW'(1);
  assign alloc_done = (MW'(acc_nxt) >= MW'(len_r));
  // A zero count gives a zero capacity, which fails any nonzero length too.
  assign space_ok   = (free_cnt_r != '0) && (MW'(len_r) <= MW'(cap_r));

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.first_block = out_first_r;
  assign out_ch.free_total  = out_free_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {fca_pkg::TAG_FREE, IW'(0)};
    rd_addr = idx_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_AEV: begin
        if (rd_tag == fca_pkg::TAG_FREE && have_prev_r) begin
          wr_en   = 1'b1;
          wr_addr = prev_r;
          wr_data = {fca_pkg::TAG_LINK, idx_r};
        end
      end
      S_AEND: begin
        wr_en   = 1'b1;
        wr_addr = prev_r;
        wr_data = {fca_pkg::TAG_END, IW'(0)};
      end
      S_FEV: begin
        wr_en = (rd_tag != fca_pkg::TAG_FREE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      free_cnt_r  <= CW'(BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is either reloaded or kept as it is.
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + IW'(1);
          if (idx_r == IW'(BLOCKS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            len_r       <= in_ch.file_length;
            idx_r       <= IW'(in_ch.start_block);
            steps_r     <= '0;
            have_prev_r <= 1'b0;
            first_idx_r <= '0;
            acc_r       <= '0;
            if (in_ch.func == fca_pkg::FUNC_ALLOC) begin
              state_r <= S_ACAP;
            end else if (32'(in_ch.start_block) >= 32'(BLOCKS)) begin
              status_r <= fca_pkg::STATUS_ALREADY_FREE;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        S_ACAP: begin
          cap_r   <= AW'(free_cnt_r) * AW'(BLOCK_BYTES);
          idx_r   <= '0;
          state_r <= S_ACHK;
        end
        S_ACHK: begin
          if (space_ok) begin
            state_r <= S_ARD;
          end else begin
            status_r <= fca_pkg::STATUS_NO_SPACE;
            state_r  <= S_OUT;
          end
        end
        S_ARD: begin
          state_r <= S_AEV;
        end
        S_AEV: begin
          if (rd_tag == fca_pkg::TAG_FREE) begin
            if (!have_prev_r) begin
              first_idx_r <= idx_r;
            end
            prev_r      <= idx_r;
            have_prev_r <= 1'b1;
            acc_r       <= acc_nxt;
            free_cnt_r  <= free_cnt_r - CW'(1);
          end
          if (rd_tag == fca_pkg::TAG_FREE && alloc_done) begin
            state_r <= S_AEND;
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_ARD;
          end
        end
        S_AEND: begin
          status_r <= fca_pkg::STATUS_OK;
          state_r  <= S_OUT;
        end
        S_FRD: begin
          state_r <= S_FEV;
        end
        S_FEV: begin
          // A free entry ends the walk; only the start block being free is an error.
          if (rd_tag == fca_pkg::TAG_FREE) begin
            status_r <= (steps_r == '0) ? fca_pkg::STATUS_ALREADY_FREE
                                        : fca_pkg::STATUS_OK;
            state_r  <= S_OUT;
          end else begin
            free_cnt_r <= free_cnt_r + CW'(1);
            steps_r    <= steps_nxt;
            idx_r      <= rd_data_r[IW-1:0];
            if (rd_tag == fca_pkg::TAG_END || steps_nxt == CW'(BLOCKS)) begin
              status_r <= fca_pkg::STATUS_OK;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_first_r  <= (status_r == fca_pkg::STATUS_OK)
                            ? fca_pkg::FIRST_W'(first_idx_r) : '0;
            out_free_r   <= fca_pkg::FREE_W'(free_cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/fca_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module fca_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/fca_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fat_chain_allocator_assert.svh"

module fca_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [fca_pkg::STATUS_W-1:0] out_status,
  input wire logic [fca_pkg::FIRST_W-1:0]  out_first_block,
  input wire logic [fca_pkg::FREE_W-1:0]   out_free_total
);

  logic out_stall;
  logic out_error;
  logic [fca_pkg::STATUS_W+fca_pkg::FIRST_W+fca_pkg::FREE_W-1:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_error   = out_valid && (out_status != fca_pkg::STATUS_OK);
  assign out_payload = {out_status, out_first_block, out_free_total};

  // Every request keeps the block busy for at least the following cycle.
  `FCA_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)

  // Only a successful allocation reports a first block.
  `FCA_ASSERT_SAME(first_zero_on_error, out_error, out_first_block == '0)

  `FCA_ASSERT_NEXT(out_holds_on_stall, out_stall, out_valid && $stable(out_payload))

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_first_block(out_ch.first_block),
  .out_free_total (out_ch.free_total)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import fca_pkg::*;

  localparam int N_BLOCKS    = 256;
  localparam int BLOCK_BYTES = 2048;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 2 * N_BLOCKS + 64;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LEN_W-1:0]   file_length;
    logic [START_W-1:0] start_block;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIRST_W-1:0]  first_block;
    logic [FREE_W-1:0]   free_total;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [START_W-1:0] link;
  } fat_entry_t;

  // Shadow copy of the allocation table; expected beats wait in arrival order.
  class chain_table_shadow;
    fat_entry_t entries[N_BLOCKS];
    int         free_count;
    result_t    pending_results[$];
    int         errors;

    function new();
      foreach (entries[i]) entries[i] = '{tag: TAG_FREE, link: '0};
      free_count = N_BLOCKS;
      errors     = 0;
    endfunction

    function bit is_taken(int b);
      return entries[b].tag != TAG_FREE;
    endfunction

    function int blocks_for(int unsigned len);
      int n;
      n = len / BLOCK_BYTES;
      if ((len % BLOCK_BYTES) != 0 || len == 0) n++;
      return n;
    endfunction

    function result_t note_request(request_t req);
      result_t    res;
      fat_entry_t e;
      int         need, got, prev, idx, steps;
      res = '0;
      if (req.func == FUNC_ALLOC) begin
        need = blocks_for(req.file_length);
        if (free_count < need) begin
          res.status = STATUS_NO_SPACE;
        end else begin
          got  = 0;
          prev = -1;
          for (int i = 0; i < N_BLOCKS && got < need; i++) begin
            if (entries[i].tag == TAG_FREE) begin
              if (prev >= 0) entries[prev] = '{tag: TAG_LINK, link: i[START_W-1:0]};
              else res.first_block = i[FIRST_W-1:0];
              prev = i;
              got++;
            end
          end
          entries[prev] = '{tag: TAG_END, link: '0};
          free_count -= got;
          res.status = STATUS_OK;
        end
      end else begin
        idx = req.start_block;
        if (idx >= N_BLOCKS || entries[idx].tag == TAG_FREE) begin
          res.status = STATUS_ALREADY_FREE;
        end else begin
          // The walk stops on a block that is already free, which happens when
          // part of the chain was released earlier from its middle.
          steps = 0;
          while (steps < N_BLOCKS) begin
            if (idx >= N_BLOCKS || entries[idx].tag == TAG_FREE) break;
            e = entries[idx];
            entries[idx] = '{tag: TAG_FREE, link: '0};
            free_count++;
            steps++;
            if (e.tag == TAG_END) break;
            idx = e.link;
          end
          res.status = STATUS_OK;
        end
      end
      res.free_total = free_count[FREE_W-1:0];
      pending_results.push_back(res);
      return res;
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (act.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, act.status);
        errors++;
      end
      if (act.first_block !== exp.first_block) begin
        $error("first_block: expected %0d, actual %0d", exp.first_block, act.first_block);
        errors++;
      end
      if (act.free_total !== exp.free_total) begin
        $error("free_total: expected %0d, actual %0d", exp.free_total, act.free_total);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  fat_chain_allocator #(
    .BLOCKS      (N_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  chain_table_shadow fat = new();
  int                gap_pct;
  int                stall_pct;
  int                hold_requests;
  byte unsigned      live_heads[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      fat.check_result('{status: out_ch.status, first_block: out_ch.first_block,
                         free_total: out_ch.free_total});
  end

  function automatic request_t alloc_req(int unsigned len);
    return '{func: FUNC_ALLOC, file_length: len[LEN_W-1:0],
             start_block: START_W'($urandom_range(0, 255))};
  endfunction

  function automatic request_t free_req(int unsigned blk);
    return '{func: FUNC_FREE, file_length: LEN_W'($urandom_range(0, 524288)),
             start_block: blk[START_W-1:0]};
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_request(input request_t req);
    result_t exp;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= req.func;
    in_ch.file_length <= req.file_length;
    in_ch.start_block <= req.start_block;
    do @(posedge clk); while (!in_ch.ready);
    exp = fat.note_request(req);
    if (req.func == FUNC_ALLOC && exp.status == STATUS_OK)
      live_heads.push_back(exp.first_block);
  endtask

  function automatic request_t random_request();
    int unsigned len;
    int          roll;
    int          blk;
    bit          want_alloc;
    roll = $urandom_range(99);
    if (fat.free_count == N_BLOCKS) want_alloc = (roll < 90);
    else if (fat.free_count < 32) want_alloc = (roll < 30);
    else want_alloc = (roll < 55);
    roll = $urandom_range(99);
    if (want_alloc) begin
      if (roll < 60) begin
        len = $urandom_range(0, 6 * BLOCK_BYTES);
      end else if (roll < 80) begin
        // Lengths right at and around a block boundary.
        len = $urandom_range(0, 16) * BLOCK_BYTES + $urandom_range(0, 2);
        if (len > 0) len = len - 1;
      end else if (roll < 95) begin
        len = $urandom_range(0, 64 * BLOCK_BYTES);
      end else begin
        len = $urandom_range(0, 524288);
      end
      return alloc_req(len);
    end
    if (roll < 60 && live_heads.size() > 0) begin
      blk = $urandom_range(0, live_heads.size() - 1);
      roll = live_heads[blk];
      live_heads.delete(blk);
      return free_req(roll);
    end
    blk = $urandom_range(0, N_BLOCKS - 1);
    if (roll < 85)
      for (int t = 0; t < 8 && !fat.is_taken(blk); t++) blk = $urandom_range(0, N_BLOCKS - 1);
    return free_req(blk);
  endfunction

  task automatic run_phase(input int n, input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n) send_request(random_request());
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (fat.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    gap_pct           = 0;
    stall_pct         = 0;
    hold_requests     = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_ALLOC;
    in_ch.file_length <= '0;
    in_ch.start_block <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: length boundaries, double frees, full table, stale links.
    send_request(alloc_req(0));
    send_request(alloc_req(1));
    send_request(alloc_req(BLOCK_BYTES));
    send_request(alloc_req(BLOCK_BYTES + 1));
    send_request(alloc_req(20'h7FFFF));
    send_request(free_req(3));
    send_request(free_req(3));
    send_request(free_req(255));
    send_request(alloc_req(3 * BLOCK_BYTES));
    send_request(free_req(4));
    send_request(free_req(3));
    send_request(free_req(0));
    send_request(free_req(1));
    send_request(free_req(2));
    send_request(alloc_req(524288));
    send_request(alloc_req(0));
    send_request(free_req(128));
    send_request(alloc_req(524288));
    send_request(free_req(0));
    send_request(alloc_req(128 * BLOCK_BYTES));
    send_request(alloc_req(128 * BLOCK_BYTES + 1));
    send_request(free_req(0));
    send_request(free_req(0));
    live_heads.delete();

    run_phase(230, 0, 0);
    run_phase(230, 75, 0);

    // Hold the result side off while requests keep coming, then let it drain.
    hold_requests++;
    run_phase(12, 0, 0);
    wait_drained();

    run_phase(230, 0, 75);
    run_phase(230, 30, 30);
    run_phase(230, 0, 0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fat.errors == 0 && fat.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/fca_pkg.sv
src/fca_in_if.sv
src/fca_out_if.sv
src/fca_table.sv
src/fat_chain_allocator.sv
src/fca_checker.sv
tb/tb.sv
